/* design/xoodoo_pkg.sv */
package xoodoo_pkg;

    localparam int LANE_W      = 32;
    localparam int LANES       = 12;
    localparam int ROUND_COUNT = 12;

    typedef logic [LANE_W-1:0] lane_t;
    typedef lane_t [LANES-1:0] state_t;

    localparam lane_t ROUND_CONSTS [ROUND_COUNT] = '{
        32'h0000_0058, 32'h0000_0038, 32'h0000_03C0, 32'h0000_00D0,
        32'h0000_0120, 32'h0000_0014, 32'h0000_0060, 32'h0000_002C,
        32'h0000_0380, 32'h0000_00F0, 32'h0000_01A0, 32'h0000_0012
    };

    function automatic lane_t rotl(lane_t v, int unsigned r);
        return (v << r) | (v >> (LANE_W - r));
    endfunction

    function automatic state_t xoodoo_round(state_t a, lane_t rc);
        lane_t  p [4];
        lane_t  e [4];
        state_t t;
        state_t b;
        state_t c;
        state_t r;
        for (int x = 0; x < 4; x++)
        begin
            p[x] = a[x] ^ a[4+x] ^ a[8+x];
        end
        for (int x = 0; x < 4; x++)
        begin
            e[x] = rotl(p[(x+3)&3], 5) ^ rotl(p[(x+3)&3], 14);
        end
        for (int x = 0; x < 4; x++)
        begin
            t[x]   = a[x]   ^ e[x];
            t[4+x] = a[4+x] ^ e[x];
            t[8+x] = a[8+x] ^ e[x];
        end
        // rho-west
        for (int x = 0; x < 4; x++)
        begin
            b[x]   = t[x];
            b[4+x] = t[4+((x+3)&3)];
            b[8+x] = rotl(t[8+x], 11);
        end
        // iota
        b[0] = b[0] ^ rc;
        // chi
        for (int x = 0; x < 4; x++)
        begin
            c[x]   = b[x]   ^ (~b[4+x] & b[8+x]);
            c[4+x] = b[4+x] ^ (~b[8+x] & b[x]);
            c[8+x] = b[8+x] ^ (~b[x]   & b[4+x]);
        end
        // rho-east
        for (int x = 0; x < 4; x++)
        begin
            r[x]   = c[x];
            r[4+x] = rotl(c[4+x], 1);
            r[8+x] = rotl(c[8+((x+2)&3)], 8);
        end
        return r;
    endfunction

endpackage

/* design/xoodoo_if.sv */
interface xoodoo_in_if;
    logic                valid;
    logic                ready;
    xoodoo_pkg::lane_t   in_plane0_col0;
    xoodoo_pkg::lane_t   in_plane0_col1;
    xoodoo_pkg::lane_t   in_plane0_col2;
    xoodoo_pkg::lane_t   in_plane0_col3;
    xoodoo_pkg::lane_t   in_plane1_col0;
    xoodoo_pkg::lane_t   in_plane1_col1;
    xoodoo_pkg::lane_t   in_plane1_col2;
    xoodoo_pkg::lane_t   in_plane1_col3;
    xoodoo_pkg::lane_t   in_plane2_col0;
    xoodoo_pkg::lane_t   in_plane2_col1;
    xoodoo_pkg::lane_t   in_plane2_col2;
    xoodoo_pkg::lane_t   in_plane2_col3;

    modport source (
        output valid,
        output in_plane0_col0, in_plane0_col1, in_plane0_col2, in_plane0_col3,
        output in_plane1_col0, in_plane1_col1, in_plane1_col2, in_plane1_col3,
        output in_plane2_col0, in_plane2_col1, in_plane2_col2, in_plane2_col3,
        input  ready
    );

    modport sink (
        input  valid,
        input  in_plane0_col0, in_plane0_col1, in_plane0_col2, in_plane0_col3,
        input  in_plane1_col0, in_plane1_col1, in_plane1_col2, in_plane1_col3,
        input  in_plane2_col0, in_plane2_col1, in_plane2_col2, in_plane2_col3,
        output ready
    );
endinterface

interface xoodoo_out_if;
    logic                valid;
    logic                ready;
    xoodoo_pkg::lane_t   out_plane0_col0;
    xoodoo_pkg::lane_t   out_plane0_col1;
    xoodoo_pkg::lane_t   out_plane0_col2;
    xoodoo_pkg::lane_t   out_plane0_col3;
    xoodoo_pkg::lane_t   out_plane1_col0;
    xoodoo_pkg::lane_t   out_plane1_col1;
    xoodoo_pkg::lane_t   out_plane1_col2;
    xoodoo_pkg::lane_t   out_plane1_col3;
    xoodoo_pkg::lane_t   out_plane2_col0;
    xoodoo_pkg::lane_t   out_plane2_col1;
    xoodoo_pkg::lane_t   out_plane2_col2;
    xoodoo_pkg::lane_t   out_plane2_col3;

    modport source (
        output valid,
        output out_plane0_col0, out_plane0_col1, out_plane0_col2, out_plane0_col3,
        output out_plane1_col0, out_plane1_col1, out_plane1_col2, out_plane1_col3,
        output out_plane2_col0, out_plane2_col1, out_plane2_col2, out_plane2_col3,
        input  ready
    );

    modport sink (
        input  valid,
        input  out_plane0_col0, out_plane0_col1, out_plane0_col2, out_plane0_col3,
        input  out_plane1_col0, out_plane1_col1, out_plane1_col2, out_plane1_col3,
        input  out_plane2_col0, out_plane2_col1, out_plane2_col2, out_plane2_col3,
        output ready
    );
endinterface

/* design/xoodoo_permutation_twelve_rounds.sv */
// Pipeline: 12 register stages, one round per stage; an accepted request moves
// through them in order, and the last stage holds its result.
// Throughput: one request per cycle while the output is not stalled; a stalled
// output holds only the stages behind it that are full, bubbles are squeezed out.
// The last round stage is the output register.
// Reset: asynchronous, active low; clears all stage valid bits, data is not reset.
module xoodoo_permutation_twelve_rounds (
    input  logic         clk,
    input  logic         rst_n,
    xoodoo_in_if.sink    up,
    xoodoo_out_if.source down
);

    localparam int N = xoodoo_pkg::ROUND_COUNT;

    logic                 valid_reg  [N];
    logic                 valid_next [N];
    xoodoo_pkg::state_t   data_reg   [N];
    xoodoo_pkg::state_t   data_next  [N];

    logic                 vin     [N+1];
    xoodoo_pkg::state_t   din     [N+1];
    logic                 advance [N+1];

    assign vin[0] = up.valid;
    assign din[0] = {up.in_plane2_col3, up.in_plane2_col2, up.in_plane2_col1,
                     up.in_plane2_col0, up.in_plane1_col3, up.in_plane1_col2,
                     up.in_plane1_col1, up.in_plane1_col0, up.in_plane0_col3,
                     up.in_plane0_col2, up.in_plane0_col1, up.in_plane0_col0};

    assign advance[N] = down.ready;
    assign up.ready   = advance[0];

    for (genvar i = 0; i < N; i++)
    begin : g_stage
        assign advance[i]   = !valid_reg[i] || advance[i+1];
        assign valid_next[i] = advance[i] ? vin[i] : valid_reg[i];
        assign data_next[i]  = xoodoo_pkg::xoodoo_round(din[i], xoodoo_pkg::ROUND_CONSTS[i]);
        assign vin[i+1]      = valid_reg[i];
        assign din[i+1]      = data_reg[i];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else
            begin
                valid_reg[i] <= valid_next[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance[i] && vin[i])
            begin
                data_reg[i] <= data_next[i];
            end
        end
    end

    assign down.valid           = valid_reg[N-1];
    assign down.out_plane0_col0 = data_reg[N-1][0];
    assign down.out_plane0_col1 = data_reg[N-1][1];
    assign down.out_plane0_col2 = data_reg[N-1][2];
    assign down.out_plane0_col3 = data_reg[N-1][3];
    assign down.out_plane1_col0 = data_reg[N-1][4];
    assign down.out_plane1_col1 = data_reg[N-1][5];
    assign down.out_plane1_col2 = data_reg[N-1][6];
    assign down.out_plane1_col3 = data_reg[N-1][7];
    assign down.out_plane2_col0 = data_reg[N-1][8];
    assign down.out_plane2_col1 = data_reg[N-1][9];
    assign down.out_plane2_col2 = data_reg[N-1][10];
    assign down.out_plane2_col3 = data_reg[N-1][11];

    // a free-flowing output lets the whole pipe move
    a_flow_through: assert property (@(posedge clk) disable iff (!rst_n)
        down.ready |-> up.ready)
        else $error("pipe blocked while output is free");

    // an empty first stage always takes a request
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !valid_reg[0] |-> up.ready)
        else $error("first stage empty but not ready");

    for (genvar k = 0; k < N; k++)
    begin : g_chk
        // a full stage that cannot move keeps its contents
        a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
            (valid_reg[k] && !advance[k]) |=> (valid_reg[k] && $stable(data_reg[k])))
            else $error("stalled stage lost or changed its contents");
    end

endmodule

/* tb/tb_xoodoo_permutation_twelve_rounds.sv */
module tb_xoodoo_permutation_twelve_rounds;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int    HALF_PERIOD   = 6;
    localparam int    CYCLE_LIMIT   = 400000;
    localparam int    ITEMS_PER_MIX = 400;
    localparam int    DRAIN_CYCLES  = 24;

    typedef struct packed {
        logic [xoodoo_pkg::LANES-1:0] lanes;
        xoodoo_pkg::lane_t            fill;
        xoodoo_pkg::lane_t            rest;
    } pattern_t;

    // lanes selected by the mask take fill, the others take rest
    localparam int       N_PATTERNS = 18;
    localparam pattern_t PATTERNS [N_PATTERNS] = '{
        '{12'h000, 32'h0000_0000, 32'h0000_0000},
        '{12'hFFF, 32'hFFFF_FFFF, 32'h0000_0000},
        '{12'hFFF, 32'hAAAA_AAAA, 32'h0000_0000},
        '{12'hFFF, 32'h5555_5555, 32'h0000_0000},
        '{12'h001, 32'h0000_0001, 32'h0000_0000},
        '{12'h001, 32'h8000_0000, 32'h0000_0000},
        '{12'h800, 32'h0000_0001, 32'h0000_0000},
        '{12'h800, 32'h8000_0000, 32'h0000_0000},
        '{12'h00F, 32'hFFFF_FFFF, 32'h0000_0000},
        '{12'h0F0, 32'hFFFF_FFFF, 32'h0000_0000},
        '{12'hF00, 32'hFFFF_FFFF, 32'h0000_0000},
        '{12'h111, 32'hFFFF_FFFF, 32'h0000_0000},
        '{12'h888, 32'hFFFF_FFFF, 32'h0000_0000},
        '{12'h020, 32'h0000_0000, 32'hFFFF_FFFF},
        '{12'h040, 32'hDEAD_BEEF, 32'h0000_0000},
        '{12'hAAA, 32'hFFFF_FFFF, 32'h0000_0000},
        '{12'h555, 32'h0000_FFFF, 32'hFFFF_0000},
        '{12'h400, 32'h0000_0000, 32'h7FFF_FFFE}
    };

    localparam xoodoo_pkg::lane_t IOTA [12] = '{
        32'h058, 32'h038, 32'h3C0, 32'h0D0, 32'h120, 32'h014,
        32'h060, 32'h02C, 32'h380, 32'h0F0, 32'h1A0, 32'h012
    };

    logic clk;
    logic rst_n;

    xoodoo_in_if  up ();
    xoodoo_out_if down ();

    xoodoo_permutation_twelve_rounds uut (
        .clk   (clk),
        .rst_n (rst_n),
        .up    (up),
        .down  (down)
    );

    xoodoo_pkg::state_t pending [$];
    xoodoo_pkg::state_t offered;
    xoodoo_pkg::state_t got;
    xoodoo_pkg::state_t want;
    int     idle_pct;
    int     stall_pct;
    int     n_sent;
    int     n_checked;
    int     n_errors;
    int     n_cycles;

    function automatic xoodoo_pkg::lane_t rol32(xoodoo_pkg::lane_t v, int n);
        logic [63:0] dbl;
        dbl = {v, v};
        return dbl[63-n -: 32];
    endfunction

    function automatic xoodoo_pkg::state_t permute_state(xoodoo_pkg::state_t s);
        xoodoo_pkg::lane_t pl  [3][4];
        xoodoo_pkg::lane_t tmp [3][4];
        xoodoo_pkg::lane_t par [4];
        xoodoo_pkg::lane_t eff;
        for (int i = 0; i < xoodoo_pkg::LANES; i++)
        begin
            pl[i/4][i%4] = s[i];
        end
        for (int r = 0; r < 12; r++)
        begin
            for (int x = 0; x < 4; x++)
            begin
                par[x] = pl[0][x] ^ pl[1][x] ^ pl[2][x];
            end
            for (int x = 0; x < 4; x++)
            begin
                eff = rol32(par[(x+3)%4], 5) ^ rol32(par[(x+3)%4], 14);
                for (int y = 0; y < 3; y++)
                begin
                    pl[y][x] ^= eff;
                end
            end
            for (int x = 0; x < 4; x++)
            begin
                tmp[0][x] = pl[0][x];
                tmp[1][x] = pl[1][(x+3)%4];
                tmp[2][x] = rol32(pl[2][x], 11);
            end
            tmp[0][0] ^= IOTA[r];
            for (int x = 0; x < 4; x++)
            begin
                pl[0][x] = tmp[0][x] ^ (~tmp[1][x] & tmp[2][x]);
                pl[1][x] = tmp[1][x] ^ (~tmp[2][x] & tmp[0][x]);
                pl[2][x] = tmp[2][x] ^ (~tmp[0][x] & tmp[1][x]);
            end
            for (int x = 0; x < 4; x++)
            begin
                tmp[0][x] = pl[0][x];
                tmp[1][x] = rol32(pl[1][x], 1);
                tmp[2][x] = rol32(pl[2][(x+2)%4], 8);
            end
            pl = tmp;
        end
        for (int i = 0; i < xoodoo_pkg::LANES; i++)
        begin
            s[i] = pl[i/4][i%4];
        end
        return s;
    endfunction

    function automatic xoodoo_pkg::lane_t rand_lane();
        case ($urandom_range(4))
            0: return xoodoo_pkg::lane_t'(1) << $urandom_range(31);
            1: return ~(xoodoo_pkg::lane_t'(1) << $urandom_range(31));
            2: return $urandom_range(1) ? '1 : '0;
            default: return $urandom;
        endcase
    endfunction

    function automatic xoodoo_pkg::state_t rand_state();
        xoodoo_pkg::state_t s;
        case ($urandom_range(5))
            0:
            begin
                // one set bit on a zero state, or one cleared bit on an all-ones state
                s = $urandom_range(1) ? '1 : '0;
                s[$urandom_range(xoodoo_pkg::LANES-1)][$urandom_range(31)] ^= 1'b1;
            end
            1:
            begin
                for (int i = 0; i < xoodoo_pkg::LANES; i++)
                begin
                    s[i] = rand_lane();
                end
            end
            default:
            begin
                for (int i = 0; i < xoodoo_pkg::LANES; i++)
                begin
                    s[i] = $urandom;
                end
            end
        endcase
        return s;
    endfunction

    task automatic send_state(input xoodoo_pkg::state_t s);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            up.valid = 1'b0;
            @(negedge clk);
        end
        up.in_plane0_col0 = s[0];
        up.in_plane0_col1 = s[1];
        up.in_plane0_col2 = s[2];
        up.in_plane0_col3 = s[3];
        up.in_plane1_col0 = s[4];
        up.in_plane1_col1 = s[5];
        up.in_plane1_col2 = s[6];
        up.in_plane1_col3 = s[7];
        up.in_plane2_col0 = s[8];
        up.in_plane2_col1 = s[9];
        up.in_plane2_col2 = s[10];
        up.in_plane2_col3 = s[11];
        up.valid = 1'b1;
        @(posedge clk);
        while (!up.ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic drain_results();
        @(negedge clk);
        up.valid = 1'b0;
        while (pending.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    always
    begin
        #(HALF_PERIOD) clk = ~clk;
    end

    always @(negedge clk)
    begin
        down.ready = ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles, %0d results outstanding",
                     $time, n_cycles, pending.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (down.valid && down.ready)
            begin
                got = {down.out_plane2_col3, down.out_plane2_col2,
                       down.out_plane2_col1, down.out_plane2_col0,
                       down.out_plane1_col3, down.out_plane1_col2,
                       down.out_plane1_col1, down.out_plane1_col0,
                       down.out_plane0_col3, down.out_plane0_col2,
                       down.out_plane0_col1, down.out_plane0_col0};
                if (pending.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, got);
                    n_errors++;
                end
                else
                begin
                    want = pending.pop_front();
                    for (int i = 0; i < xoodoo_pkg::LANES; i++)
                    begin
                        if (got[i] !== want[i])
                        begin
                            $display("%0t: out_plane%0d_col%0d expected %h actual %h",
                                     $time, i / 4, i % 4, want[i], got[i]);
                            n_errors++;
                        end
                    end
                    n_checked++;
                end
            end
            if (up.valid && up.ready)
            begin
                offered = {up.in_plane2_col3, up.in_plane2_col2,
                           up.in_plane2_col1, up.in_plane2_col0,
                           up.in_plane1_col3, up.in_plane1_col2,
                           up.in_plane1_col1, up.in_plane1_col0,
                           up.in_plane0_col3, up.in_plane0_col2,
                           up.in_plane0_col1, up.in_plane0_col0};
                pending.push_back(permute_state(offered));
                n_sent++;
            end
        end
    end

    initial
    begin
        xoodoo_pkg::state_t s;
        int     mix_idle  [4];
        int     mix_stall [4];
        clk       = 1'b0;
        rst_n     = 1'b0;
        idle_pct  = 0;
        stall_pct = 0;
        n_sent    = 0;
        n_checked = 0;
        n_errors  = 0;
        n_cycles  = 0;
        up.valid  = 1'b0;
        {up.in_plane0_col0, up.in_plane0_col1, up.in_plane0_col2, up.in_plane0_col3,
         up.in_plane1_col0, up.in_plane1_col1, up.in_plane1_col2, up.in_plane1_col3,
         up.in_plane2_col0, up.in_plane2_col1, up.in_plane2_col2, up.in_plane2_col3} = '0;
        down.ready = 1'b0;
        mix_idle  = '{0, 48, 0, 15};
        mix_stall = '{0, 0, 48, 15};

        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        for (int k = 0; k < N_PATTERNS; k++)
        begin
            for (int i = 0; i < xoodoo_pkg::LANES; i++)
            begin
                s[i] = PATTERNS[k].lanes[i] ? PATTERNS[k].fill : PATTERNS[k].rest;
            end
            send_state(s);
        end
        // hold off until the pipeline is empty
        drain_results();

        for (int m = 0; m < 4; m++)
        begin
            idle_pct  = mix_idle[m];
            stall_pct = mix_stall[m];
            for (int k = 0; k < ITEMS_PER_MIX; k++)
            begin
                send_state(rand_state());
            end
            drain_results();
        end

        stall_pct = 0;
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d of %0d permutation requests (%0d directed patterns),",
                 n_checked, n_sent, N_PATTERNS);
        $display("under free flow, sender gaps, output stalls and both; %0d mismatches.",
                 n_errors);
        if (n_errors == 0 && pending.size() == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
